>>> rtl/core/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared constants, types and lookup functions for the motor feedback
// frame parser: sync bytes, frame lengths, word store geometry and the
// readout order of the result words.
// ----------------------------------------------------------------------------
`default_nettype none

package mfp_pkg;

  // Sync pair, low byte first on the wire
  localparam logic [7:0] SYNC_LO = 8'hCD;
  localparam logic [7:0] SYNC_HI = 8'hAB;

  localparam int SHORT_FRAME_BYTES = 18;
  localparam int LONG_FRAME_BYTES  = 26;

  // Byte counter holds 0..LONG_FRAME_BYTES
  localparam int CNT_W = $clog2(LONG_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] SHORT_CNT = CNT_W'(SHORT_FRAME_BYTES);
  localparam logic [CNT_W-1:0] LONG_CNT  = CNT_W'(LONG_FRAME_BYTES);

  // Word store: one 16-bit little-endian word per byte pair
  localparam int WORDS  = LONG_FRAME_BYTES / 2;
  localparam int ADDR_W = $clog2(WORDS);

  // Word positions inside a frame
  localparam logic [ADDR_W-1:0] W_SPEED_R    = ADDR_W'(3);
  localparam logic [ADDR_W-1:0] W_SPEED_L    = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] W_SHORT_BATT = ADDR_W'(5);
  localparam logic [ADDR_W-1:0] W_SHORT_TEMP = ADDR_W'(6);
  localparam logic [ADDR_W-1:0] W_CUR_L      = ADDR_W'(7);
  localparam logic [ADDR_W-1:0] W_CUR_R      = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] W_LONG_BATT  = ADDR_W'(9);
  localparam logic [ADDR_W-1:0] W_LONG_TEMP  = ADDR_W'(10);

  // Readout step counter (at most six words per result)
  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    FLD_SPEED_R,
    FLD_SPEED_L,
    FLD_CUR_L,
    FLD_CUR_R,
    FLD_BATT,
    FLD_TEMP
  } fld_t;

  // Write port of the word store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } ram_wr_t;

  // Result request from the framer
  typedef struct packed {
    logic valid;
    logic is_short;
  } emit_t;

  // Word address for each readout step
  function automatic logic [ADDR_W-1:0] rd_word(input logic is_short,
                                                input logic [STEP_W-1:0] step);
    logic [ADDR_W-1:0] a;
    a = W_SPEED_R;
    case (step)
      3'd0:    a = W_SPEED_R;
      3'd1:    a = W_SPEED_L;
      3'd2:    a = is_short ? W_SHORT_BATT : W_CUR_L;
      3'd3:    a = is_short ? W_SHORT_TEMP : W_CUR_R;
      3'd4:    a = W_LONG_BATT;
      3'd5:    a = W_LONG_TEMP;
      default: a = W_SPEED_R;
    endcase
    return a;
  endfunction

  // Result field filled by each readout step
  function automatic fld_t rd_field(input logic is_short,
                                    input logic [STEP_W-1:0] step);
    fld_t f;
    f = FLD_SPEED_R;
    case (step)
      3'd0:    f = FLD_SPEED_R;
      3'd1:    f = FLD_SPEED_L;
      3'd2:    f = is_short ? FLD_BATT : FLD_CUR_L;
      3'd3:    f = is_short ? FLD_TEMP : FLD_CUR_R;
      3'd4:    f = FLD_BATT;
      3'd5:    f = FLD_TEMP;
      default: f = FLD_SPEED_R;
    endcase
    return f;
  endfunction

  // Final step of a readout
  function automatic logic rd_last(input logic is_short,
                                   input logic [STEP_W-1:0] step);
    return is_short ? (step == 3'd3) : (step == 3'd5);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mfp_if.sv
// ----------------------------------------------------------------------------
// mfp_if
// Valid/ready channel interfaces of the frame parser: received byte
// channel and decoded feedback result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface mfp_out_if;
  logic               valid;
  logic               ready;
  logic               is_short_format;
  logic signed [15:0] speed_right;
  logic signed [15:0] speed_left;
  logic signed [15:0] current_left;
  logic signed [15:0] current_right;
  logic signed [15:0] battery_raw;
  logic signed [15:0] board_temp_raw;

  modport source (output valid, output is_short_format, output speed_right,
                  output speed_left, output current_left, output current_right,
                  output battery_raw, output board_temp_raw, input ready);
  modport sink   (input valid, input is_short_format, input speed_right,
                  input speed_left, input current_left, input current_right,
                  input battery_raw, input board_temp_raw, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mfp_word_ram.sv
// ----------------------------------------------------------------------------
// mfp_word_ram
// Frame word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_word_ram
  import mfp_pkg::*;
(
  input  wire logic              clk,
  input  wire ram_wr_t           wr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [15:0]       rd_data
);

  logic [15:0] mem [WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mfp_framer.sv
// ----------------------------------------------------------------------------
// mfp_framer
// Sync hunt, byte counting, running XOR check and format lock. Completed
// byte pairs are written to the word store; a passing check raises a
// result request.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_framer
  import mfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       beat,
  input  wire logic       command,
  input  wire logic [7:0] rx_byte,
  output ram_wr_t         wr,
  output emit_t           emit
);

  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             hunt_r,   hunt_nxt;
  logic [15:0]      xor_r,    xor_nxt;
  logic             locked_r, locked_nxt;
  logic             short_r,  short_nxt;
  logic [7:0]       low_r,    low_nxt;

  logic [15:0]      xor_upd;
  logic [CNT_W-1:0] cnt_inc;

  // Next-state logic for one beat
  always_comb begin
    cnt_nxt    = cnt_r;
    hunt_nxt   = hunt_r;
    xor_nxt    = xor_r;
    locked_nxt = locked_r;
    short_nxt  = short_r;
    low_nxt    = low_r;
    wr         = '0;
    emit       = '0;
    xor_upd    = cnt_r[0] ? (xor_r ^ {rx_byte, 8'h00}) : (xor_r ^ {8'h00, rx_byte});
    cnt_inc    = cnt_r + CNT_W'(1);

    if (beat) begin
      if (command) begin
        // clear framing and format detection
        cnt_nxt    = '0;
        hunt_nxt   = 1'b1;
        xor_nxt    = '0;
        locked_nxt = 1'b0;
        short_nxt  = 1'b0;
      end else if (hunt_r) begin
        if (cnt_r == CNT_W'(0)) begin
          if (rx_byte == SYNC_LO) begin
            cnt_nxt = CNT_W'(1);
          end
        end else if (cnt_r == CNT_W'(1)) begin
          if (rx_byte == SYNC_HI) begin
            cnt_nxt  = CNT_W'(2);
            hunt_nxt = 1'b0;
            xor_nxt  = {SYNC_HI, SYNC_LO};
          end else if (rx_byte == SYNC_LO) begin
            cnt_nxt = CNT_W'(1);
          end else begin
            cnt_nxt = '0;
          end
        end
      end else if (cnt_r >= LONG_CNT) begin
        cnt_nxt  = '0;
        hunt_nxt = 1'b1;
        xor_nxt  = '0;
      end else begin
        // collect byte; odd byte completes a word
        cnt_nxt = cnt_inc;
        xor_nxt = xor_upd;
        if (cnt_r[0]) begin
          wr.en   = 1'b1;
          wr.addr = cnt_r[CNT_W-1:1];
          wr.data = {rx_byte, low_r};
        end else begin
          low_nxt = rx_byte;
        end

        if (cnt_inc == SHORT_CNT && (!locked_r || short_r)) begin
          if (xor_upd == 16'h0000) begin
            locked_nxt    = 1'b1;
            short_nxt     = 1'b1;
            emit.valid    = 1'b1;
            emit.is_short = 1'b1;
            cnt_nxt       = '0;
            hunt_nxt      = 1'b1;
            xor_nxt       = '0;
          end else if (locked_r) begin
            cnt_nxt  = '0;
            hunt_nxt = 1'b1;
            xor_nxt  = '0;
          end
        end else if (cnt_inc == LONG_CNT) begin
          if (xor_upd == 16'h0000) begin
            locked_nxt    = 1'b1;
            short_nxt     = 1'b0;
            emit.valid    = 1'b1;
            emit.is_short = 1'b0;
          end
          cnt_nxt  = '0;
          hunt_nxt = 1'b1;
          xor_nxt  = '0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      hunt_r   <= 1'b1;
      xor_r    <= '0;
      locked_r <= 1'b0;
      short_r  <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      hunt_r   <= hunt_nxt;
      xor_r    <= xor_nxt;
      locked_r <= locked_nxt;
      short_r  <= short_nxt;
    end
  end

  // Low byte of the word being assembled
  always_ff @(posedge clk) begin
    low_r <= low_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/mfp_readout.sv
// ----------------------------------------------------------------------------
// mfp_readout
// Reads the result words of a checked frame from the word store, one per
// cycle, into a staging set, then hands it to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_readout
  import mfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire emit_t             emit,
  output logic                   rd_en,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [15:0]       rd_data,
  output logic                   stage_full,
  mfp_out_if.source              out_bus
);

  // Read sequencer
  logic              act_r,   act_nxt;
  logic              rshort_r, rshort_nxt;
  logic [STEP_W-1:0] step_r,  step_nxt;
  logic              dv_r;
  fld_t              dfld_r;
  logic              dlast_r;

  // Staging set
  logic               stage_full_r, stage_full_nxt;
  logic               st_short_r;
  logic signed [15:0] st_spd_r_r, st_spd_l_r, st_cur_l_r, st_cur_r_r;
  logic signed [15:0] st_batt_r, st_temp_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               o_short_r;
  logic signed [15:0] o_spd_r_r, o_spd_l_r, o_cur_l_r, o_cur_r_r, o_batt_r, o_temp_r;

  logic load_out;

  assign rd_en   = act_r;
  assign rd_addr = rd_word(rshort_r, step_r);

  assign load_out = stage_full_r && (!out_valid_r || out_bus.ready);

  always_comb begin
    act_nxt    = act_r;
    rshort_nxt = rshort_r;
    step_nxt   = step_r;
    if (emit.valid) begin
      act_nxt    = 1'b1;
      rshort_nxt = emit.is_short;
      step_nxt   = '0;
    end else if (act_r) begin
      step_nxt = step_r + STEP_W'(1);
      if (rd_last(rshort_r, step_r)) begin
        act_nxt = 1'b0;
      end
    end

    stage_full_nxt = stage_full_r;
    if (load_out) begin
      stage_full_nxt = 1'b0;
    end else if (dv_r && dlast_r) begin
      stage_full_nxt = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r        <= 1'b0;
      dv_r         <= 1'b0;
      stage_full_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      act_r        <= act_nxt;
      dv_r         <= act_r;
      stage_full_r <= stage_full_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Sequencer payload
  always_ff @(posedge clk) begin
    rshort_r <= rshort_nxt;
    step_r   <= step_nxt;
    dfld_r   <= rd_field(rshort_r, step_r);
    dlast_r  <= rd_last(rshort_r, step_r);
  end

  // Staging capture: format and zero currents at request, words as read
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      st_short_r <= emit.is_short;
      st_cur_l_r <= '0;
      st_cur_r_r <= '0;
    end
    if (dv_r) begin
      unique case (dfld_r)
        FLD_SPEED_R: st_spd_r_r <= rd_data;
        FLD_SPEED_L: st_spd_l_r <= rd_data;
        FLD_CUR_L:   st_cur_l_r <= rd_data;
        FLD_CUR_R:   st_cur_r_r <= rd_data;
        FLD_BATT:    st_batt_r  <= rd_data;
        FLD_TEMP:    st_temp_r  <= rd_data;
      endcase
    end
  end

  // Output register load
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_short_r <= st_short_r;
      o_spd_r_r <= st_spd_r_r;
      o_spd_l_r <= st_spd_l_r;
      o_cur_l_r <= st_cur_l_r;
      o_cur_r_r <= st_cur_r_r;
      o_batt_r  <= st_batt_r;
      o_temp_r  <= st_temp_r;
    end
  end

  assign stage_full              = stage_full_r;
  assign out_bus.valid           = out_valid_r;
  assign out_bus.is_short_format = o_short_r;
  assign out_bus.speed_right     = o_spd_r_r;
  assign out_bus.speed_left      = o_spd_l_r;
  assign out_bus.current_left    = o_cur_l_r;
  assign out_bus.current_right   = o_cur_r_r;
  assign out_bus.battery_raw     = o_batt_r;
  assign out_bus.board_temp_raw  = o_temp_r;

endmodule

`default_nettype wire

>>> rtl/core/motor_feedback_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_parser
// Sync-word framer for motor feedback frames with a 16-bit XOR check;
// decodes short (18 byte) and long (26 byte) frames.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------------------
//  in_bus   | in  | command, rx_byte (one received byte or a clear command)
//  out_bus  | out | is_short_format, speeds, currents, battery, temperature
//
//  One byte beat per cycle unless stalled; count and XOR update in that cycle.
//  A passing frame is read back from the word store one word a cycle
//  (4 reads short, 6 long) into a staging set, then to the output register.
//  in_bus.ready drops only while a staged result sits behind a valid output beat.
//  Synchronous active-low reset; the word store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_feedback_frame_parser
  import mfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mfp_in_if.sink    in_bus,
  mfp_out_if.source out_bus
);

  logic              beat;
  logic              stage_full;
  logic              in_stall;
  ram_wr_t           wr;
  emit_t             emit;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0]       rd_data;

  // Staging set drains into a free output register in the same cycle
  assign in_stall     = stage_full && out_bus.valid;
  assign in_bus.ready = !in_stall;
  assign beat         = in_bus.valid && !in_stall;

  mfp_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .command (in_bus.command),
    .rx_byte (in_bus.rx_byte),
    .wr      (wr),
    .emit    (emit)
  );

  mfp_word_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mfp_readout u_readout (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .stage_full (stage_full),
    .out_bus    (out_bus)
  );

endmodule

`default_nettype wire

>>> rtl/core/mfp_checker.sv
// ----------------------------------------------------------------------------
// mfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mfp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_short,
  input wire logic signed [15:0] out_speed_right,
  input wire logic signed [15:0] out_current_left,
  input wire logic signed [15:0] out_current_right
);

  // A stalled result stays valid and keeps its speed_right
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed_right))
    else $error("result changed while stalled");

  // Nothing offered right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // Short frames carry no current readings
  a_short_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short |-> out_current_left == 16'sd0 &&
                               out_current_right == 16'sd0)
    else $error("short result with non-zero current");

  // Sustained input back-pressure only behind a pending result
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && $past(!in_ready) |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind motor_feedback_frame_parser mfp_checker u_mfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_short         (out_bus.is_short_format),
  .out_speed_right   (out_bus.speed_right),
  .out_current_left  (out_bus.current_left),
  .out_current_right (out_bus.current_right)
);

`default_nettype wire

>>> sim/motor_feedback_frame_parser_test.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_parser_test
// Self-checking bench for the feedback frame parser. A queue of byte and
// clear beats (directed frames first, then random sessions of short and long
// frames mixed with noise, bad checksums and cut-off frames) is driven in
// random bursts. A local frame tracker predicts each decoded result, and the
// monitor checks every output beat against it under random sink stalls.
// ----------------------------------------------------------------------------

module motor_feedback_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mfp_pkg::*;

  localparam int RANDOM_BEATS = 1480;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } rx_beat_t;

  typedef struct packed {
    logic               is_short;
    logic signed [15:0] speed_right;
    logic signed [15:0] speed_left;
    logic signed [15:0] current_left;
    logic signed [15:0] current_right;
    logic signed [15:0] battery_raw;
    logic signed [15:0] board_temp_raw;
  } feedback_t;

  // Payload patterns for generated frames
  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_EDGE} fill_t;

  // Sink pacing modes
  typedef enum int {PACE_FULL, PACE_THIRD, PACE_LIGHT, PACE_HEAVY} sink_pace_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic hold_off = 1'b0;

  mfp_in_if  in_bus ();
  mfp_out_if out_bus ();

  motor_feedback_frame_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  rx_beat_t   pending_q[$];
  feedback_t  feedback_q[$];
  feedback_t  want_fb;
  int         err_cnt = 0;
  int         beats_sent = 0;
  int         cycle_cnt = 0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         pace_left = 0;
  int         pace_tick = 0;
  sink_pace_t pace = PACE_FULL;
  logic       sink_ready;

  // Frame tracker state
  logic [7:0]  frame_buf [0:LONG_FRAME_BYTES-1];
  logic [4:0]  buf_cnt;
  logic        in_hunt;
  logic [15:0] chk_xor;
  logic        fmt_known;
  logic        fmt_is_short;

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Frame tracker
  // --------------------------------------------------------------------------
  task automatic restart_framing();
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    buf_cnt = '0;
    in_hunt = 1'b1;
    chk_xor = '0;
  endtask

  function automatic logic [15:0] buf_word(input int pos);
    return {frame_buf[pos+1], frame_buf[pos]};
  endfunction

  function automatic void push_feedback(input logic short_fmt);
    feedback_t r;
    r.is_short    = short_fmt;
    r.speed_right = buf_word(6);
    r.speed_left  = buf_word(8);
    if (short_fmt) begin
      r.current_left   = '0;
      r.current_right  = '0;
      r.battery_raw    = buf_word(10);
      r.board_temp_raw = buf_word(12);
    end else begin
      r.current_left   = buf_word(14);
      r.current_right  = buf_word(16);
      r.battery_raw    = buf_word(18);
      r.board_temp_raw = buf_word(20);
    end
    feedback_q.push_back(r);
  endfunction

  // One accepted beat through the framer
  task automatic track_beat(input rx_beat_t b);
    if (b.command) begin
      restart_framing();
      fmt_known    = 1'b0;
      fmt_is_short = 1'b0;
      return;
    end
    // sync hunt: CD AB, a repeated CD stays primed
    if (in_hunt) begin
      if (buf_cnt == 0) begin
        if (b.rx_byte == SYNC_LO) begin
          frame_buf[0] = b.rx_byte;
          buf_cnt      = 5'd1;
        end
      end else if (buf_cnt == 1) begin
        if (b.rx_byte == SYNC_HI) begin
          frame_buf[1] = b.rx_byte;
          buf_cnt      = 5'd2;
          in_hunt      = 1'b0;
          chk_xor      = {SYNC_HI, SYNC_LO};
        end else if (b.rx_byte == SYNC_LO) begin
          frame_buf[0] = b.rx_byte;
          buf_cnt      = 5'd1;
        end else begin
          buf_cnt = '0;
        end
      end
      return;
    end
    if (buf_cnt >= LONG_FRAME_BYTES) begin
      restart_framing();
      return;
    end
    // collect, little-endian word XOR
    frame_buf[buf_cnt] = b.rx_byte;
    if (buf_cnt[0]) chk_xor ^= {b.rx_byte, 8'h00};
    else            chk_xor ^= {8'h00, b.rx_byte};
    buf_cnt++;
    if (buf_cnt == SHORT_FRAME_BYTES && (!fmt_known || fmt_is_short)) begin
      if (chk_xor == '0) begin
        fmt_known    = 1'b1;
        fmt_is_short = 1'b1;
        push_feedback(1'b1);
        restart_framing();
        return;
      end
      if (fmt_known) begin
        restart_framing();
        return;
      end
    end
    if (buf_cnt == LONG_FRAME_BYTES) begin
      if (chk_xor == '0) begin
        fmt_known    = 1'b1;
        fmt_is_short = 1'b0;
        push_feedback(1'b0);
      end
      restart_framing();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_beat(input logic command, input logic [7:0] rx_byte);
    rx_beat_t b;
    b.command = command;
    b.rx_byte = rx_byte;
    pending_q.push_back(b);
  endtask

  function automatic logic [7:0] pick_byte(input fill_t fill, input int pos);
    logic [7:0] v;
    case (fill)
      FILL_ZERO: v = 8'h00;
      FILL_ONES: v = 8'hFF;
      // words alternate 0x8000 / 0x7FFF
      FILL_EDGE: v = pos[0] ? (pos[1] ? 8'h7F : 8'h80) : (pos[1] ? 8'hFF : 8'h00);
      default:   v = 8'($urandom);
    endcase
    return v;
  endfunction

  // Build a frame with a zeroing checksum word at the end. split also makes
  // the first nine words of a long frame XOR to zero; cut sends only the first bytes.
  task automatic queue_frame(input logic long_fmt, input logic corrupt,
                             input logic split, input fill_t fill, input int cut);
    logic [7:0]  fr [0:LONG_FRAME_BYTES-1];
    logic [15:0] x;
    int          n;
    int          i;
    int          p;
    n = long_fmt ? LONG_FRAME_BYTES : SHORT_FRAME_BYTES;
    fr[0] = SYNC_LO;
    fr[1] = SYNC_HI;
    for (i = 2; i < n; i++) fr[i] = pick_byte(fill, i);
    if (split && long_fmt) begin
      x = '0;
      for (i = 0; i < 8; i++) x ^= {fr[2*i+1], fr[2*i]};
      fr[16] = x[7:0];
      fr[17] = x[15:8];
    end
    x = '0;
    for (i = 0; i < n/2 - 1; i++) x ^= {fr[2*i+1], fr[2*i]};
    fr[n-2] = x[7:0];
    fr[n-1] = x[15:8];
    if (corrupt) begin
      p = $urandom_range(2, n - 1);
      fr[p] ^= 8'(1 << $urandom_range(0, 7));
    end
    if (cut > 0 && cut < n) n = cut;
    for (i = 0; i < n; i++) add_beat(1'b0, fr[i]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int    target;
    int    pick;
    logic  sess_long;
    logic  fmt_long;
    fill_t fill;

    in_bus.valid   = 1'b0;
    in_bus.command = 1'b0;
    in_bus.rx_byte = 8'h00;
    out_bus.ready  = 1'b0;
    restart_framing();
    fmt_known    = 1'b0;
    fmt_is_short = 1'b0;

    // noise, broken hunt, primed hunt into a short frame
    add_beat(1'b0, 8'h00);
    add_beat(1'b0, 8'hFF);
    add_beat(1'b0, SYNC_LO);
    add_beat(1'b0, 8'h00);
    add_beat(1'b0, SYNC_LO);
    add_beat(1'b0, SYNC_LO);
    queue_frame(1'b0, 1'b0, 1'b0, FILL_EDGE, 0);
    // bad short while locked short, then recovery
    queue_frame(1'b0, 1'b1, 1'b0, FILL_RAND, 0);
    queue_frame(1'b0, 1'b0, 1'b0, FILL_ONES, 0);
    // clear, then a long frame failing the short check on the way
    add_beat(1'b1, 8'hFF);
    queue_frame(1'b1, 1'b0, 1'b0, FILL_EDGE, 0);
    // locked long: no short check even when the first nine words cancel
    queue_frame(1'b1, 1'b0, 1'b0, FILL_ONES, 0);
    queue_frame(1'b1, 1'b0, 1'b1, FILL_RAND, 0);
    queue_frame(1'b1, 1'b1, 1'b0, FILL_RAND, 0);
    // clear in mid-frame, then a split long frame read as short
    queue_frame(1'b1, 1'b0, 1'b0, FILL_RAND, 10);
    add_beat(1'b1, 8'h00);
    queue_frame(1'b1, 1'b0, 1'b1, FILL_RAND, 0);
    queue_frame(1'b0, 1'b0, 1'b0, FILL_ZERO, 0);

    // random sessions: mostly well-formed frames of one format
    target    = pending_q.size() + RANDOM_BEATS;
    sess_long = 1'($urandom_range(0, 1));
    while (pending_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        add_beat(1'b1, 8'($urandom));
        sess_long = 1'($urandom_range(0, 1));
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 6))
          add_beat(1'b0, ($urandom_range(0, 3) == 0) ? SYNC_LO : 8'($urandom));
      end else if (pick < 12) begin
        queue_frame(sess_long, 1'b0, 1'b0, FILL_RAND, $urandom_range(1, 17));
        add_beat(1'b1, 8'($urandom));
        sess_long = 1'($urandom_range(0, 1));
      end else begin
        fmt_long = ($urandom_range(0, 9) == 0) ? !sess_long : sess_long;
        fill = ($urandom_range(0, 19) == 0) ? fill_t'($urandom_range(1, 3)) : FILL_RAND;
        queue_frame(fmt_long, $urandom_range(0, 6) == 0,
                    fmt_long && ($urandom_range(0, 9) == 0), fill, 0);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || feedback_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Long sink hold-off so the output path backs up into the input
  initial begin
    wait (beats_sent >= 500);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        track_beat(pending_q[0]);
        void'(pending_q.pop_front());
        beats_sent++;
      end
      // hold the beat while it is refused
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else begin
          in_bus.valid   <= 1'b1;
          in_bus.command <= pending_q[0].command;
          in_bus.rx_byte <= pending_q[0].rx_byte;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink pacing
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace      = sink_pace_t'($urandom_range(0, 3));
        pace_left = $urandom_range(20, 120);
      end else begin
        pace_left--;
      end
      pace_tick++;
      case (pace)
        PACE_FULL:  sink_ready = 1'b1;
        PACE_THIRD: sink_ready = (pace_tick % 3) != 0;
        PACE_LIGHT: sink_ready = $urandom_range(0, 3) != 0;
        default:    sink_ready = $urandom_range(0, 3) == 0;
      endcase
      out_bus.ready <= sink_ready && !hold_off;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each result beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (feedback_q.size() == 0) begin
        report_mismatch("result beat with no frame pending");
      end else begin
        want_fb = feedback_q.pop_front();
        compare_field("is_short_format", 16'(out_bus.is_short_format),
                      16'(want_fb.is_short));
        compare_field("speed_right", out_bus.speed_right, want_fb.speed_right);
        compare_field("speed_left", out_bus.speed_left, want_fb.speed_left);
        compare_field("current_left", out_bus.current_left, want_fb.current_left);
        compare_field("current_right", out_bus.current_right, want_fb.current_right);
        compare_field("battery_raw", out_bus.battery_raw, want_fb.battery_raw);
        compare_field("board_temp_raw", out_bus.board_temp_raw,
                      want_fb.board_temp_raw);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

endmodule
